// ===== rtl/core/bxp_pkg.sv =====
// ----------------------------------------------------------------------------
// bxp_pkg
// Shared widths, constants and types for the binary XNOR-popcount tile.
// ----------------------------------------------------------------------------
package bxp_pkg;

   localparam int SLICE_W    = 64;  // width of the packed operand ports
   localparam int COORD_W    = 3;   // tile row / column port width
   localparam int CNT_W      = 16;  // mismatch counter width
   localparam int DOT_W      = 17;  // signed dot product width
   localparam int CFG_W      = 16;  // vector_bits register width
   localparam int LANE_W     = 8;   // operand bits handled by one lane
   localparam int LANE_CNT_W = $clog2(LANE_W + 1);

   localparam logic [CFG_W-1:0] VECTOR_BITS_RST = 16'd128;
   localparam logic [CNT_W-1:0] CNT_MAX         = '1;

   typedef logic [LANE_CNT_W-1:0] lane_cnt_type;
   typedef logic [CNT_W-1:0]      cnt_type;

endpackage

// ===== rtl/core/bxp_ram.sv =====
// ----------------------------------------------------------------------------
// bxp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bxp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bxp_lane.sv =====
// ----------------------------------------------------------------------------
// bxp_lane
// One popcount lane: XOR of an operand byte pair, count of the differing
// bits, registered on load.
// ----------------------------------------------------------------------------
module bxp_lane
   import bxp_pkg::*;
#(
   parameter int ACTIVE_BITS = 8
) (
   input  logic              clock,
   input  logic              load,
   input  logic [LANE_W-1:0] a_bits,
   input  logic [LANE_W-1:0] b_bits,
   output lane_cnt_type      count
);

   logic [LANE_W-1:0] diff;
   lane_cnt_type      count_in;
   lane_cnt_type      count_ff;

   always_comb begin
      diff     = a_bits ^ b_bits;
      count_in = '0;
      for (int i = 0; i < LANE_W; i++) begin
         // drop bits past the end of the slice
         if (i < ACTIVE_BITS) begin
            count_in = count_in + lane_cnt_type'(diff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== rtl/core/bxp_merge.sv =====
// ----------------------------------------------------------------------------
// bxp_merge
// Sums the lane counts and adds them into a stored mismatch count,
// saturating at the counter maximum.
// ----------------------------------------------------------------------------
module bxp_merge
   import bxp_pkg::*;
#(
   parameter int LANES = 8,
   parameter int POP_W = 7
) (
   input  logic [LANES-1:0][LANE_CNT_W-1:0] lane_cnt,
   input  cnt_type                          base_cnt,
   output cnt_type                          sum_cnt
);

   logic [POP_W-1:0] pop;
   logic [CNT_W:0]   total;

   always_comb begin
      pop = '0;
      for (int l = 0; l < LANES; l++) begin
         pop = pop + POP_W'(lane_cnt[l]);
      end
      total   = {1'b0, base_cnt} + (CNT_W + 1)'(pop);
      sum_cnt = total[CNT_W] ? CNT_MAX : total[CNT_W-1:0];
   end

endmodule

// ===== rtl/core/binary_xnor_popcount_gemm_tile_unit.sv =====
// ----------------------------------------------------------------------------
// binary_xnor_popcount_gemm_tile_unit
// Path: a final in-tile word passes the s1 stage register, then the
//   response registers, which raise its result strobe.
// Flow: an in-tile word holds off the next word during the read-modify-write
//   of the counter RAM (busy for one cycle); out-of-tile words do not set busy.
// Reset clears all tile counters (valid bits), control state and sets
//   vector_bits to 128. The receiver cannot stall.
// ----------------------------------------------------------------------------
module binary_xnor_popcount_gemm_tile_unit
   import bxp_pkg::*;
#(
   parameter int TILE_ROWS  = 8,
   parameter int TILE_COLS  = 8,
   parameter int SLICE_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic [SLICE_W-1:0]         req_a_slice,
   input  logic [SLICE_W-1:0]         req_b_slice,
   input  logic [COORD_W-1:0]         req_tile_row,
   input  logic [COORD_W-1:0]         req_tile_col,
   input  logic                       req_final_slice,
   // response channel
   output logic                       rsp_strobe,
   output logic signed [DOT_W-1:0]    rsp_dot_value,
   output logic [COORD_W-1:0]         rsp_out_row,
   output logic [COORD_W-1:0]         rsp_out_col,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_data
);

   localparam int LANES = (SLICE_BITS + LANE_W - 1) / LANE_W;
   localparam int POP_W = $clog2(SLICE_BITS + 1);
   localparam int DEPTH = TILE_ROWS * TILE_COLS;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int POS_W = 9;  // holds row * TILE_COLS + col for any legal tile

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
      logic               hit;
   } s1_type;

   logic                            accept;
   logic                            in_tile;
   logic [POS_W-1:0]                pos;
   logic [IDX_W-1:0]                idx;

   logic                            s1_valid_ff, s1_valid_in;
   s1_type                          s1_ff, s1_in;
   logic [DEPTH-1:0]                valid_ff, valid_in;
   logic [CFG_W-1:0]                vector_bits_ff;

   logic [LANES-1:0][LANE_CNT_W-1:0] lane_cnt;
   cnt_type                         rd_cnt;
   cnt_type                         base_cnt;
   cnt_type                         sum_cnt;
   logic [DOT_W:0]                  dot_full;

   logic                            rsp_strobe_ff;
   logic [DOT_W-1:0]                rsp_dot_ff;
   logic [COORD_W-1:0]              rsp_row_ff, rsp_col_ff;

   // ---------------------------------------------------------------- accept
   assign busy   = s1_valid_ff;
   assign accept = start && !busy;

   assign in_tile = (5'(req_tile_row) < 5'(TILE_ROWS)) &&
                    (5'(req_tile_col) < 5'(TILE_COLS));
   assign pos     = POS_W'(req_tile_row) * POS_W'(TILE_COLS) + POS_W'(req_tile_col);
   assign idx     = pos[IDX_W-1:0];

   always_comb begin
      s1_valid_in = accept && in_tile;
      s1_in.idx   = idx;
      s1_in.row   = req_tile_row;
      s1_in.col   = req_tile_col;
      s1_in.last  = req_final_slice;
      s1_in.hit   = valid_ff[idx];
   end

   // ----------------------------------------------------------------- lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      localparam int REMAIN = SLICE_BITS - l * LANE_W;
      localparam int ACTIVE = (REMAIN < LANE_W) ? REMAIN : LANE_W;

      bxp_lane #(
         .ACTIVE_BITS (ACTIVE)
      ) u_lane (
         .clock  (clock),
         .load   (accept),
         .a_bits (req_a_slice[l*LANE_W +: LANE_W]),
         .b_bits (req_b_slice[l*LANE_W +: LANE_W]),
         .count  (lane_cnt[l])
      );
   end

   // ----------------------------------------------------------- counter RAM
   bxp_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && !s1_ff.last),
      .wr_addr (s1_ff.idx),
      .wr_data (sum_cnt),
      .rd_en   (s1_valid_in),
      .rd_addr (idx),
      .rd_data (rd_cnt)
   );

   // never-written or cleared entries read as zero
   assign base_cnt = s1_ff.hit ? rd_cnt : '0;

   bxp_merge #(
      .LANES (LANES),
      .POP_W (POP_W)
   ) u_merge (
      .lane_cnt (lane_cnt),
      .base_cnt (base_cnt),
      .sum_cnt  (sum_cnt)
   );

   assign dot_full = (DOT_W + 1)'(vector_bits_ff) - (DOT_W + 1)'({sum_cnt, 1'b0});

   always_comb begin
      valid_in = valid_ff;
      if (s1_valid_ff) begin
         // final word clears the entry, others mark it live
         valid_in[s1_ff.idx] = !s1_ff.last;
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         valid_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
         vector_bits_ff <= VECTOR_BITS_RST;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= s1_valid_ff && s1_ff.last;
         if (csr_valid && csr_ready) begin
            vector_bits_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff) begin
         rsp_dot_ff <= dot_full[DOT_W-1:0];
         rsp_row_ff <= s1_ff.row;
         rsp_col_ff <= s1_ff.col;
      end
   end

   assign csr_ready     = 1'b1;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_dot_value = signed'(rsp_dot_ff);
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;

`ifndef NO_ASSERTIONS
   a_busy_one_cycle : assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_strobe_after_final : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(s1_valid_ff) && $past(s1_ff.last)))
      else $error("result strobe without a final word in flight");

   a_final_clears_entry : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.last) |=> !valid_ff[$past(s1_ff.idx)])
      else $error("final word did not clear its counter entry");

   a_partial_marks_entry : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ff.last) |=> valid_ff[$past(s1_ff.idx)])
      else $error("partial word did not mark its counter entry");
`endif

endmodule
